>>> hdl/csvc_pkg.sv
package csvc_pkg;

	localparam int NUM_REFERENCES = 3;
	localparam int PERIOD_BITS = 16;
	localparam int REF_BITS = 3 * PERIOD_BITS;
	localparam int VOTE_BITS = 16;

	localparam logic [VOTE_BITS-1:0] VOTE_MAX = 16'hFFFF;
	localparam logic [15:0] TOLERANCE_RESET = 16'd10;
	localparam logic [15:0] MIN_VOTES_RESET = 16'd300;

	// Configuration register indexes.
	localparam logic [2:0] REG_REF_ONE = 3'd0;
	localparam logic [2:0] REG_REF_TWO = 3'd1;
	localparam logic [2:0] REG_REF_THREE = 3'd2;
	localparam logic [2:0] REG_TOLERANCE = 3'd3;
	localparam logic [2:0] REG_MIN_VOTES = 3'd4;

	// Match codes carried in the queue; the bin codes share the same values.
	localparam logic [1:0] MATCH_ONE = 2'd0;
	localparam logic [1:0] MATCH_TWO = 2'd1;
	localparam logic [1:0] MATCH_THREE = 2'd2;
	localparam logic [1:0] MATCH_NONE = 2'd3;
	localparam logic [1:0] BIN_OTHER = 2'd3;

	localparam logic [6:0] ANGLE_BIN_ZERO = 7'd0;
	localparam logic [6:0] ANGLE_BIN_ONE = 7'd23;
	localparam logic [6:0] ANGLE_BIN_TWO = 7'd46;
	localparam logic [6:0] ANGLE_OTHER = 7'd70;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [NUM_REFERENCES-1:0][REF_BITS-1:0] ref_color;
		logic [15:0] tolerance;
		logic [15:0] min_votes;
	} cfg_t;

	typedef struct packed {
		logic [1:0] match;
		logic window_end;
	} entry_t;

	function automatic logic [6:0] chute_of(input logic [1:0] bin_code);
		logic [6:0] angle;
		case (bin_code)
			MATCH_ONE: angle = ANGLE_BIN_ZERO;
			MATCH_TWO: angle = ANGLE_BIN_ONE;
			MATCH_THREE: angle = ANGLE_BIN_TWO;
			default: angle = ANGLE_OTHER;
		endcase
		return angle;
	endfunction

endpackage

>>> hdl/csvc_front.sv
module csvc_front #(
	parameter int CHANNEL_BITS = 16
) (
	input logic in_valid,
	input logic [15:0] red_period,
	input logic [15:0] green_period,
	input logic [15:0] blue_period,
	input logic window_end,
	input csvc_pkg::cfg_t cfg,
	input logic queue_full,
	output logic in_stall,
	output logic push,
	output csvc_pkg::entry_t push_entry
);

	logic [2:0][CHANNEL_BITS-1:0] reading;
	logic [csvc_pkg::NUM_REFERENCES-1:0] hit;

	assign reading[0] = red_period[CHANNEL_BITS-1:0];
	assign reading[1] = green_period[CHANNEL_BITS-1:0];
	assign reading[2] = blue_period[CHANNEL_BITS-1:0];

	// A reference is hit when every channel lies within the tolerance.
	always_comb begin
		logic [CHANNEL_BITS-1:0] ref_chan;
		logic [CHANNEL_BITS-1:0] diff;
		for (int r = 0; r < csvc_pkg::NUM_REFERENCES; r++) begin
			hit[r] = 1'b1;
			for (int c = 0; c < 3; c++) begin
				ref_chan = cfg.ref_color[r][c*csvc_pkg::PERIOD_BITS +: CHANNEL_BITS];
				diff = (reading[c] >= ref_chan) ? (reading[c] - ref_chan)
					: (ref_chan - reading[c]);
				if (17'(diff) > 17'(cfg.tolerance)) begin
					hit[r] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		if (hit[0]) begin
			push_entry.match = csvc_pkg::MATCH_ONE;
		end else if (hit[1]) begin
			push_entry.match = csvc_pkg::MATCH_TWO;
		end else if (hit[2]) begin
			push_entry.match = csvc_pkg::MATCH_THREE;
		end else begin
			push_entry.match = csvc_pkg::MATCH_NONE;
		end
		push_entry.window_end = window_end;
	end

	assign in_stall = queue_full;
	assign push = in_valid && !queue_full;

endmodule

>>> hdl/csvc_queue.sv
module csvc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input csvc_pkg::entry_t push_entry,
	input logic pop,
	output logic full,
	output logic head_valid,
	output csvc_pkg::entry_t head_entry
);

	csvc_pkg::entry_t [csvc_pkg::QUEUE_DEPTH-1:0] slot_q;
	logic [csvc_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [csvc_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [csvc_pkg::QUEUE_CW-1:0] count_q;
	logic do_pop;

	assign full = (count_q == csvc_pkg::QUEUE_CW'(csvc_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == csvc_pkg::QUEUE_AW'(csvc_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == csvc_pkg::QUEUE_AW'(csvc_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/csvc_back.sv
module csvc_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input csvc_pkg::entry_t head_entry,
	input logic [15:0] min_votes,
	input logic out_stall,
	output logic pop,
	output logic out_valid,
	output logic [1:0] bin,
	output logic [6:0] chute_angle,
	output logic [15:0] votes_one,
	output logic [15:0] votes_two,
	output logic [15:0] votes_three,
	output logic [15:0] tally_one,
	output logic [15:0] tally_two,
	output logic [15:0] tally_three,
	output logic [15:0] tally_other
);

	logic [csvc_pkg::NUM_REFERENCES-1:0][csvc_pkg::VOTE_BITS-1:0] votes_q;
	logic [csvc_pkg::NUM_REFERENCES-1:0][csvc_pkg::VOTE_BITS-1:0] votes_next;
	logic [3:0][15:0] tally_q;
	logic [3:0][15:0] tally_next;
	logic [1:0] bin_next;
	logic out_valid_q;
	logic load_out;
	logic [1:0] bin_q;
	logic [6:0] chute_angle_q;
	logic [15:0] votes_one_q;
	logic [15:0] votes_two_q;
	logic [15:0] votes_three_q;
	logic [15:0] tally_one_q;
	logic [15:0] tally_two_q;
	logic [15:0] tally_three_q;
	logic [15:0] tally_other_q;

	// An item without a result may always leave; one with a result needs
	// the output register free or being emptied this cycle.
	assign pop = head_valid && (!head_entry.window_end || !out_valid_q || !out_stall);
	assign load_out = pop && head_entry.window_end;

	always_comb begin
		logic [csvc_pkg::VOTE_BITS-1:0] best;
		logic all_low;
		for (int r = 0; r < csvc_pkg::NUM_REFERENCES; r++) begin
			votes_next[r] = votes_q[r];
			if (head_entry.match == 2'(r) && votes_q[r] != csvc_pkg::VOTE_MAX) begin
				votes_next[r] = votes_q[r] + 1'b1;
			end
		end
		best = '0;
		bin_next = csvc_pkg::MATCH_ONE;
		all_low = 1'b1;
		for (int r = 0; r < csvc_pkg::NUM_REFERENCES; r++) begin
			if (votes_next[r] > best) begin
				best = votes_next[r];
				bin_next = 2'(r);
			end
			if (votes_next[r] > min_votes) begin
				all_low = 1'b0;
			end
		end
		if (all_low) begin
			bin_next = csvc_pkg::BIN_OTHER;
		end
		tally_next = tally_q;
		if (tally_q[bin_next] != csvc_pkg::VOTE_MAX) begin
			tally_next[bin_next] = tally_q[bin_next] + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			votes_q <= '0;
			tally_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				votes_q <= head_entry.window_end ? '0 : votes_next;
			end
			if (load_out) begin
				tally_q <= tally_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			bin_q <= bin_next;
			chute_angle_q <= csvc_pkg::chute_of(bin_next);
			votes_one_q <= votes_next[0];
			votes_two_q <= votes_next[1];
			votes_three_q <= votes_next[2];
			tally_one_q <= tally_next[0];
			tally_two_q <= tally_next[1];
			tally_three_q <= tally_next[2];
			tally_other_q <= tally_next[3];
		end
	end

	assign out_valid = out_valid_q;
	assign bin = bin_q;
	assign chute_angle = chute_angle_q;
	assign votes_one = votes_one_q;
	assign votes_two = votes_two_q;
	assign votes_three = votes_three_q;
	assign tally_one = tally_one_q;
	assign tally_two = tally_two_q;
	assign tally_three = tally_three_q;
	assign tally_other = tally_other_q;

endmodule

>>> hdl/color_sample_vote_classifier_unit.sv
// Color sample vote classifier.
//
// Input channel (in_valid / in_stall): one red, green and blue period reading
// per item plus window_end, which marks the last reading of a voting window.
// Output channel (out_valid / out_stall): one result item for each input item
// with window_end set, carrying the bin, chute angle, closed window votes and
// the saturating bin tallies. Items without window_end produce no result.
// Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
// indexes 0..2 write the reference colors, 3 the tolerance, 4 the minimum
// vote count. Other indexes are ignored. Write only while the block is idle.
//
// Throughput is one item per cycle while in_stall is low. The front
// classifies a reading in the cycle it is accepted and the item enters the
// queue at that edge; once it reaches the queue head, the back end updates
// votes from it and, at a window end, the tallies and its output register.
// While the receiver stalls a result, the back end keeps consuming items
// without results; once a second result waits at the queue head, the four
// entry queue fills and in_stall rises. Reset clears votes, tallies, the
// queue and the output valid, and loads tolerance 10 and minimum 300.
module color_sample_vote_classifier_unit #(
	parameter int CHANNEL_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [15:0] red_period,
	input logic [15:0] green_period,
	input logic [15:0] blue_period,
	input logic window_end,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] bin,
	output logic [6:0] chute_angle,
	output logic [15:0] votes_one,
	output logic [15:0] votes_two,
	output logic [15:0] votes_three,
	output logic [15:0] tally_one,
	output logic [15:0] tally_two,
	output logic [15:0] tally_three,
	output logic [15:0] tally_other,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data
);

	csvc_pkg::cfg_t cfg_q;
	logic push;
	csvc_pkg::entry_t push_entry;
	logic queue_full;
	logic head_valid;
	csvc_pkg::entry_t head_entry;
	logic pop;

	// The register file never refuses a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_color <= '0;
			cfg_q.tolerance <= csvc_pkg::TOLERANCE_RESET;
			cfg_q.min_votes <= csvc_pkg::MIN_VOTES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				csvc_pkg::REG_REF_ONE: cfg_q.ref_color[0] <= cfg_data;
				csvc_pkg::REG_REF_TWO: cfg_q.ref_color[1] <= cfg_data;
				csvc_pkg::REG_REF_THREE: cfg_q.ref_color[2] <= cfg_data;
				csvc_pkg::REG_TOLERANCE: cfg_q.tolerance <= cfg_data[15:0];
				csvc_pkg::REG_MIN_VOTES: cfg_q.min_votes <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The front end finds the first reference that the reading matches.
	csvc_front #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_front (
		.in_valid(in_valid),
		.red_period(red_period),
		.green_period(green_period),
		.blue_period(blue_period),
		.window_end(window_end),
		.cfg(cfg_q),
		.queue_full(queue_full),
		.in_stall(in_stall),
		.push(push),
		.push_entry(push_entry)
	);

	// Classified items wait here so that the two ends can stall apart.
	csvc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.full(queue_full),
		.head_valid(head_valid),
		.head_entry(head_entry)
	);

	// The back end counts votes, decides the bin at window end and
	// holds the result until the receiver takes it.
	csvc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.min_votes(cfg_q.min_votes),
		.out_stall(out_stall),
		.pop(pop),
		.out_valid(out_valid),
		.bin(bin),
		.chute_angle(chute_angle),
		.votes_one(votes_one),
		.votes_two(votes_two),
		.votes_three(votes_three),
		.tally_one(tally_one),
		.tally_two(tally_two),
		.tally_three(tally_three),
		.tally_other(tally_other)
	);

endmodule

>>> hdl/csvc_checker.sv
module csvc_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] bin,
	input logic [6:0] chute_angle,
	input logic [15:0] votes_one,
	input logic [15:0] votes_two,
	input logic [15:0] votes_three
);

	// No result is shown while reset is held.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// A stalled result stays in place.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bin) && $stable(votes_one))
		else $error("stalled result changed");

	// The chute angle follows the bin.
	a_chute: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(bin == csvc_pkg::MATCH_ONE && chute_angle == csvc_pkg::ANGLE_BIN_ZERO) ||
			(bin == csvc_pkg::MATCH_TWO && chute_angle == csvc_pkg::ANGLE_BIN_ONE) ||
			(bin == csvc_pkg::MATCH_THREE && chute_angle == csvc_pkg::ANGLE_BIN_TWO) ||
			(bin == csvc_pkg::BIN_OTHER && chute_angle == csvc_pkg::ANGLE_OTHER))
		else $error("chute angle does not match bin");

	// A reference bin holds the largest vote, lowest index on ties.
	a_winner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bin == csvc_pkg::BIN_OTHER) ||
			(bin == csvc_pkg::MATCH_ONE && votes_one >= votes_two
				&& votes_one >= votes_three) ||
			(bin == csvc_pkg::MATCH_TWO && votes_two > votes_one
				&& votes_two >= votes_three) ||
			(bin == csvc_pkg::MATCH_THREE && votes_three > votes_one
				&& votes_three > votes_two))
		else $error("bin is not the vote winner");

endmodule

bind color_sample_vote_classifier_unit csvc_checker u_csvc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.bin(bin),
	.chute_angle(chute_angle),
	.votes_one(votes_one),
	.votes_two(votes_two),
	.votes_three(votes_three)
);
